### hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and codes of the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_TEMP_TRIM  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_HIGH = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_NINE = 2'd3;

  // side data that rides along the divider
  typedef struct packed {
    logic [14:0] temp;
    logic        zero;
  } side_t;

endpackage
`default_nettype wire

### hw/rtl/bpc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels for raw readings and compensated results.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] temp_raw;
  logic [19:0] press_raw;
  modport source (output valid, temp_raw, press_raw, input ready);
  modport sink (input valid, temp_raw, press_raw, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temp_centi;
  logic        [31:0] press_q24_8;
  logic               divisor_zero;
  modport source (output valid, temp_centi, press_q24_8, divisor_zero, input ready);
  modport sink (input valid, temp_centi, press_q24_8, divisor_zero, output ready);
endinterface
`default_nettype wire

### hw/rtl/baro_pressure_compensation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_pressure_compensation_top
// Integer temperature and pressure compensation of raw 20-bit readings.
// ----------------------------------------------------------------------------
// Takes one raw temperature/pressure pair per cycle while the skid entry of the
// output buffer is empty, and returns one result per pair, in order. The
// pressure path holds a 64-stage bit-per-stage signed divider; the polynomial
// stages around it use 33x33 or smaller multipliers with a register after
// each. A two-entry output buffer lets the pipeline keep accepting while one
// result waits. Write trim registers only while no item is in flight.
module baro_pressure_compensation_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [63:0]                     cfg_data_i,
  bpc_in_if.sink                          in_i,
  bpc_out_if.source                       out_o
);

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] mul_lo(input logic [31:0] a, input logic [15:0] b);
    logic signed [48:0] pr;
    pr = $signed({1'b0, a}) * $signed(b);
    return {{15{pr[48]}}, pr};
  endfunction

  function automatic logic [31:0] mul_hi(input logic [31:0] a, input logic [15:0] b);
    return a * {{16{b[15]}}, b};
  endfunction

  function automatic logic [63:0] mul_lou(input logic [31:0] a, input logic [15:0] b);
    logic [47:0] pr;
    pr = a * b;
    return {16'd0, pr};
  endfunction

  function automatic logic [31:0] mul_hiu(input logic [31:0] a, input logic [15:0] b);
    return a * {16'd0, b};
  endfunction

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return {32'd0, a} * {32'd0, b};
  endfunction

  // trim registers
  logic [47:0] temp_trim_q;
  logic [63:0] plo_q;
  logic [63:0] phi_q;
  logic [15:0] p9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0;
      plo_q       <= '0;
      phi_q       <= '0;
      p9_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpc_pkg::CFG_TEMP_TRIM:  temp_trim_q <= cfg_data_i[47:0];
        bpc_pkg::CFG_PRESS_LOW:  plo_q       <= cfg_data_i;
        bpc_pkg::CFG_PRESS_HIGH: phi_q       <= cfg_data_i;
        bpc_pkg::CFG_PRESS_NINE: p9_q        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8;
  assign t1 = temp_trim_q[15:0];
  assign t2 = temp_trim_q[31:16];
  assign t3 = temp_trim_q[47:32];
  assign p1 = plo_q[15:0];
  assign p2 = plo_q[31:16];
  assign p3 = plo_q[47:32];
  assign p4 = plo_q[63:48];
  assign p5 = phi_q[15:0];
  assign p6 = phi_q[31:16];
  assign p7 = phi_q[47:32];
  assign p8 = phi_q[63:48];

  // pipeline control
  logic adv;
  logic skid_v_q;
  assign adv      = ~skid_v_q;
  assign in_i.ready = adv;

  logic [11:1] vld_q;
  logic        dv;
  logic [6:1]  pv_q;
  logic [63:0] dq;
  bpc_pkg::side_t dside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      pv_q  <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[10:1], in_i.valid};
      pv_q  <= {pv_q[5:1], dv};
    end
  end

  // temperature stages
  logic [31:0] a32, d32, prod1_q, dd_q, v1_q, m_q, fine_q, ddsh, msh, tw;
  logic signed [31:0] ts, tc;
  logic [20:0] p21_q [1:8];
  logic [14:0] temp_q [4:11];

  assign a32  = {15'd0, in_i.temp_raw[19:3]} - {15'd0, t1, 1'b0};
  assign d32  = {16'd0, in_i.temp_raw[19:4]} - {16'd0, t1};
  assign ddsh = asr32(dd_q, 12);
  assign msh  = asr32(m_q, 14);
  assign tw   = fine_q * 32'd5 + 32'd128;
  assign ts   = $signed(tw) >>> 8;

  always_comb begin
    tc = ts;
    if (ts < -32'sd4000) tc = -32'sd4000;
    if (ts > 32'sd8500)  tc = 32'sd8500;
  end

  // pressure stages
  logic signed [32:0] x1_q;
  logic signed [65:0] sq66;
  logic signed [48:0] a5_q [5:7];
  logic signed [48:0] a2_q [5:7];
  logic [63:0] sq_q, lo6_q, lo3_q, v6_q, v3_q, x2_q, x1b_q, y_q, nb_q;
  logic [31:0] hi6_q, hi3_q, yhi_q, nhi_q;
  logic [63:0] ylo_q, nlo_q, den_q, num_q;

  assign sq66 = x1_q * x1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod1_q  <= a32 * {{16{t2[15]}}, t2};
      dd_q     <= d32 * d32;
      p21_q[1] <= 21'h100000 - {1'b0, in_i.press_raw};
      v1_q     <= asr32(prod1_q, 11);
      m_q      <= ddsh * {{16{t3[15]}}, t3};
      fine_q   <= v1_q + msh;
      for (int i = 2; i <= 8; i++) p21_q[i] <= p21_q[i-1];
      temp_q[4] <= tc[14:0];
      for (int i = 5; i <= 11; i++) temp_q[i] <= temp_q[i-1];
      x1_q     <= $signed({fine_q[31], fine_q}) - 33'sd128000;
      sq_q     <= sq66[63:0];
      a5_q[5]  <= x1_q * $signed(p5);
      a2_q[5]  <= x1_q * $signed(p2);
      for (int i = 6; i <= 7; i++) begin
        a5_q[i] <= a5_q[i-1];
        a2_q[i] <= a2_q[i-1];
      end
      lo6_q    <= mul_lo(sq_q[31:0], p6);
      hi6_q    <= mul_hi(sq_q[63:32], p6);
      lo3_q    <= mul_lo(sq_q[31:0], p3);
      hi3_q    <= mul_hi(sq_q[63:32], p3);
      v6_q     <= lo6_q + {hi6_q, 32'd0};
      v3_q     <= lo3_q + {hi3_q, 32'd0};
      x2_q     <= v6_q + ({{15{a5_q[7][48]}}, a5_q[7]} << 17)
                  + ({{48{p4[15]}}, p4} << 35);
      x1b_q    <= asr64(v3_q, 8) + ({{15{a2_q[7][48]}}, a2_q[7]} << 12);
      y_q      <= 64'h0000_8000_0000_0000 + x1b_q;
      nb_q     <= ({43'd0, p21_q[8]} << 31) - x2_q;
      ylo_q    <= mul_lou(y_q[31:0], p1);
      yhi_q    <= mul_hiu(y_q[63:32], p1);
      nlo_q    <= mul_lou(nb_q[31:0], 16'd3125);
      nhi_q    <= mul_hiu(nb_q[63:32], 16'd3125);
      den_q    <= asr64(ylo_q + {yhi_q, 32'd0}, 33);
      num_q    <= nlo_q + {nhi_q, 32'd0};
    end
  end

  bpc_pkg::side_t side_in;
  assign side_in.temp = temp_q[11];
  assign side_in.zero = (den_q == 64'd0);

  bpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_q[11]),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (side_in),
    .valid_o (dv),
    .quot_o  (dq),
    .side_o  (dside)
  );

  // post-division stages
  logic [63:0] pp_q [1:5];
  bpc_pkg::side_t ps_q [1:6];
  logic [63:0] h_q, p8lo_q, ll_q, p8s_q, hh_q, y1lo_q, y1_q, s_q;
  logic [31:0] p8hi_q, lh_q, y1hi_q;
  logic [63:0] y2_q [3:5];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q[1] <= dq;
      for (int i = 2; i <= 5; i++) pp_q[i] <= pp_q[i-1];
      ps_q[1] <= dside;
      for (int i = 2; i <= 6; i++) ps_q[i] <= ps_q[i-1];
      h_q     <= asr64(dq, 13);
      p8lo_q  <= mul_lo(dq[31:0], p8);
      p8hi_q  <= mul_hi(dq[63:32], p8);
      ll_q    <= mul32(h_q[31:0], h_q[31:0]);
      lh_q    <= h_q[31:0] * h_q[63:32];
      p8s_q   <= p8lo_q + {p8hi_q, 32'd0};
      hh_q    <= ll_q + {lh_q[30:0], 1'b0, 32'd0};
      y2_q[3] <= asr64(p8s_q, 19);
      y2_q[4] <= y2_q[3];
      y2_q[5] <= y2_q[4];
      y1lo_q  <= mul_lo(hh_q[31:0], p9_q);
      y1hi_q  <= mul_hi(hh_q[63:32], p9_q);
      y1_q    <= asr64(y1lo_q + {y1hi_q, 32'd0}, 25);
      s_q     <= pp_q[5] + y1_q + y2_q[5];
    end
  end

  logic [31:0] press_w;
  assign press_w = ps_q[6].zero ? 32'd0 : (s_q[39:8] + {{12{p7[15]}}, p7, 4'd0});

  // output buffer with skid entry
  logic        out_v_q;
  logic [14:0] out_t_q, skid_t_q;
  logic [31:0] out_p_q, skid_p_q;
  logic        out_z_q, skid_z_q;
  logic        push, pop;

  assign push = adv & pv_q[6];
  assign pop  = out_v_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (push) begin
      if (out_v_q && !pop) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_t_q <= skid_t_q;
        out_p_q <= skid_p_q;
        out_z_q <= skid_z_q;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_t_q <= ps_q[6].temp;
        skid_p_q <= press_w;
        skid_z_q <= ps_q[6].zero;
      end else begin
        out_t_q <= ps_q[6].temp;
        out_p_q <= press_w;
        out_z_q <= ps_q[6].zero;
      end
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.temp_centi   = $signed(out_t_q);
  assign out_o.press_q24_8  = out_p_q;
  assign out_o.divisor_zero = out_z_q;

  a_skid_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry without head entry");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid filled without output stall");

  a_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_z_q) |-> (out_p_q == 32'd0))
    else $error("zero divisor with nonzero pressure");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ($signed(out_t_q) >= -15'sd4000 && $signed(out_t_q) <= 15'sd8500))
    else $error("temperature out of range");

endmodule
`default_nettype wire

### hw/rtl/bpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module bpc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  input  bpc_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [63:0]         quot_o,
  output bpc_pkg::side_t      side_o
);

  localparam int unsigned Steps = 64;

  logic [63:0]    rem_q  [Steps+1];
  logic [63:0]    num_q  [Steps+1];
  logic [63:0]    den_q  [Steps+1];
  logic           neg_q  [Steps+1];
  bpc_pkg::side_t side_q [Steps+1];
  logic [Steps:0] vld_q;

  logic [63:0]    quot_q;
  bpc_pkg::side_t sout_q;
  logic           vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      vld_q  <= {vld_q[Steps-1:0], valid_i};
      vout_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      num_q[0]  <= num_i[63] ? (64'd0 - num_i) : num_i;
      den_q[0]  <= den_i[63] ? (64'd0 - den_i) : den_i;
      neg_q[0]  <= num_i[63] ^ den_i[63];
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [64:0] sh;
    logic [64:0] diff;
    assign sh   = {rem_q[k], num_q[k][63]};
    assign diff = sh - {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[64]) begin
          rem_q[k+1] <= diff[63:0];
          num_q[k+1] <= {num_q[k][62:0], 1'b1};
        end else begin
          rem_q[k+1] <= sh[63:0];
          num_q[k+1] <= {num_q[k][62:0], 1'b0};
        end
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= neg_q[Steps] ? (64'd0 - num_q[Steps]) : num_q[Steps];
      sout_q <= side_q[Steps];
    end
  end

  assign valid_o = vout_q;
  assign quot_o  = quot_q;
  assign side_o  = sout_q;

endmodule
`default_nettype wire

### tb/baro_pressure_compensation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_compensation_checker
// Watches the trim port and both channels. Predicts each compensated result
// in 32-bit (temperature) and 64-bit (pressure) integer arithmetic and checks
// the results in order against the block.
// ----------------------------------------------------------------------------
module baro_pressure_compensation_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                 cfg_data_i,
  bpc_in_if                           in_mon,
  bpc_out_if                          out_mon,
  output int                          errors_o,
  output int                          pending_o,
  output int                          readings_o,
  output int                          zero_div_o
);

  typedef struct packed {
    logic [14:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        divisor_zero;
  } comp_result_t;

  logic [47:0] temp_trim_q;
  logic [63:0] press_low_q;
  logic [63:0] press_high_q;
  logic [15:0] press_nine_q;

  comp_result_t compensated_q[$];

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] q;
    un = n[63] ? 64'd0 - n : n;
    ud = d[63] ? 64'd0 - d : d;
    q  = un / ud;
    return (n[63] != d[63]) ? 64'd0 - q : q;
  endfunction

  function automatic comp_result_t compensate(input logic [19:0] t_raw,
                                               input logic [19:0] p_raw);
    logic [31:0] at, t1, t2, t3, v1, v2, d, tmp, fine;
    logic signed [31:0] tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] x1, x2, p, h, y1, y2, w;
    comp_result_t r;
    at  = {12'd0, t_raw};
    t1  = {16'd0, temp_trim_q[15:0]};
    t2  = {{16{temp_trim_q[31]}}, temp_trim_q[31:16]};
    t3  = {{16{temp_trim_q[47]}}, temp_trim_q[47:32]};
    tmp = ((at >> 3) - (t1 << 1)) * t2;
    v1  = $signed(tmp) >>> 11;
    d   = (at >> 4) - t1;
    tmp = d * d;
    tmp = $signed(tmp) >>> 12;
    tmp = tmp * t3;
    v2  = $signed(tmp) >>> 14;
    fine = v1 + v2;
    tmp = fine * 32'd5 + 32'd128;
    tc  = $signed(tmp) >>> 8;
    if (tc < -32'sd4000) tc = -32'sd4000;
    if (tc > 32'sd8500) tc = 32'sd8500;
    r.temp_centi = tc[14:0];

    p1 = {48'd0, press_low_q[15:0]};
    p2 = sext16(press_low_q[31:16]);
    p3 = sext16(press_low_q[47:32]);
    p4 = sext16(press_low_q[63:48]);
    p5 = sext16(press_high_q[15:0]);
    p6 = sext16(press_high_q[31:16]);
    p7 = sext16(press_high_q[47:32]);
    p8 = sext16(press_high_q[63:48]);
    p9 = sext16(press_nine_q);
    x1 = {{32{fine[31]}}, fine} - 64'd128000;
    x2 = x1 * x1 * p6;
    w  = x1 * p5;
    x2 = x2 + (w << 17) + (p4 << 35);
    w  = x1 * x1 * p3;
    w  = $signed(w) >>> 8;
    x1 = w + ((x1 * p2) << 12);
    w  = ((64'd1 << 47) + x1) * p1;
    x1 = $signed(w) >>> 33;
    r.press_q24_8  = '0;
    r.divisor_zero = 1'b0;
    if (x1 == 64'd0) begin
      r.divisor_zero = 1'b1;
    end else begin
      p  = 64'd1048576 - {44'd0, p_raw};
      p  = div_trunc(((p << 31) - x2) * 64'd3125, x1);
      h  = $signed(p) >>> 13;
      w  = p9 * h * h;
      y1 = $signed(w) >>> 25;
      w  = p8 * p;
      y2 = $signed(w) >>> 19;
      w  = p + y1 + y2;
      p  = ($signed(w) >>> 8) + (p7 << 4);
      r.press_q24_8 = p[31:0];
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o   = 0;
    readings_o = 0;
    zero_div_o = 0;
  end

  assign pending_o = compensated_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    comp_result_t want;
    if (!rst_ni) begin
      temp_trim_q  <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_nine_q <= '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (compensated_q.size() == 0) begin
          report("unexpected item", {32'd0, out_mon.press_q24_8}, 64'd0);
        end else begin
          want = compensated_q.pop_front();
          if (out_mon.temp_centi !== want.temp_centi)
            report("temp_centi", {49'd0, out_mon.temp_centi}, {49'd0, want.temp_centi});
          if (out_mon.press_q24_8 !== want.press_q24_8)
            report("press_q24_8", {32'd0, out_mon.press_q24_8}, {32'd0, want.press_q24_8});
          if (out_mon.divisor_zero !== want.divisor_zero)
            report("divisor_zero", {63'd0, out_mon.divisor_zero},
                   {63'd0, want.divisor_zero});
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = compensate(in_mon.temp_raw, in_mon.press_raw);
        compensated_q.push_back(want);
        readings_o++;
        if (want.divisor_zero) zero_div_o++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bpc_pkg::CFG_TEMP_TRIM:  temp_trim_q  <= cfg_data_i[47:0];
          bpc_pkg::CFG_PRESS_LOW:  press_low_q  <= cfg_data_i;
          bpc_pkg::CFG_PRESS_HIGH: press_high_q <= cfg_data_i;
          bpc_pkg::CFG_PRESS_NINE: press_nine_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/baro_pressure_compensation_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_compensation_top_test
// Drives trim settings and raw reading pairs with random idle gaps on both
// channels; the checker predicts and compares every compensated result.
// ----------------------------------------------------------------------------
module baro_pressure_compensation_top_test;

  localparam int Phases    = 8;
  localparam int PerPhase  = 228;
  localparam int IdleLimit = 20000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [bpc_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [63:0]                 cfg_data_i = '0;
  int errors, pending, readings, zero_divs;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  baro_pressure_compensation_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i(in_ch), .out_o(out_ch)
  );

  baro_pressure_compensation_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_mon(in_ch), .out_mon(out_ch),
    .errors_o(errors), .pending_o(pending), .readings_o(readings), .zero_div_o(zero_divs)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ch.ready = 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_reading(input logic [19:0] t_raw, input logic [19:0] p_raw);
    int g;
    in_ch.valid     = 1'b1;
    in_ch.temp_raw  = t_raw;
    in_ch.press_raw = p_raw;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_trim(input logic [bpc_pkg::CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_trims(input int phase);
    logic [63:0] tt, pl, ph, pn;
    case (phase)
      0: begin
        tt = {16'd0, 16'hFC18, 16'h6743, 16'd27504};
        pl = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
        ph = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        pn = 64'd6000;
      end
      1: begin
        tt = '1; pl = '1; ph = '1; pn = '1;
      end
      2: begin
        tt = {16'd0, 16'h8000, 16'h7FFF, 16'hFFFF};
        pl = {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF};
        ph = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        pn = 64'h8000;
      end
      3: begin
        tt = {16'd0, 16'h7FFF, 16'h8000, 16'h0000};
        pl = {16'h8000, 16'h7FFF, 16'h8000, 16'h0001};
        ph = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        pn = 64'h7FFF;
      end
      4: begin
        tt = {$urandom, $urandom};
        pl = 64'h0;
        ph = {$urandom, $urandom};
        pn = {$urandom, $urandom};
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          tt = {16'd0, 16'hFC18 + 16'($urandom_range(0, 200)),
                16'h6743 + 16'($urandom_range(0, 800)),
                16'd27000 + 16'($urandom_range(0, 1000))};
          pl = {16'd2800 + 16'($urandom_range(0, 200)), 16'd3000 + 16'($urandom_range(0, 50)),
                16'hD643 + 16'($urandom_range(0, 400)), 16'd36000 + 16'($urandom_range(0, 900))};
          ph = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140} ^ 64'($urandom_range(0, 255));
          pn = {$urandom, $urandom};
        end else begin
          tt = {$urandom, $urandom};
          pl = {$urandom, $urandom};
          ph = {$urandom, $urandom};
          pn = {$urandom, $urandom};
        end
      end
    endcase
    write_trim(bpc_pkg::CFG_TEMP_TRIM, tt);
    write_trim(bpc_pkg::CFG_PRESS_LOW, pl);
    write_trim(bpc_pkg::CFG_PRESS_HIGH, ph);
    write_trim(bpc_pkg::CFG_PRESS_NINE, pn);
  endtask

  initial begin
    logic [19:0] edge_vals [4];
    edge_vals = '{20'h00000, 20'hFFFFF, 20'hAAAAA, 20'h55555};
    in_ch.valid = 1'b0;
    in_ch.temp_raw = '0;
    in_ch.press_raw = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_reading(20'h80000, 20'h65A30);
    send_reading(20'hFFFFF, 20'h00000);
    drain();
    for (int ph = 0; ph < Phases; ph++) begin
      set_trims(ph);
      no_idle = (ph == 3) || (ph == 6);
      if (ph == 0) begin
        foreach (edge_vals[i])
          foreach (edge_vals[j]) send_reading(edge_vals[i], edge_vals[j]);
        send_reading(20'd519888, 20'd415148);
      end
      for (int k = 0; k < PerPhase; k++) begin
        if (ph == 2 && k == PerPhase / 2) begin
          in_ch.valid = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        if ($urandom_range(0, 9) < 7)
          send_reading(20'd400000 + 20'($urandom_range(0, 250000)),
                       20'd250000 + 20'($urandom_range(0, 300000)));
        else
          send_reading(20'($urandom), 20'($urandom));
      end
      drain();
    end
    $display("Covered %0d readings over %0d trim settings, %0d with a zero divisor.",
             readings, Phases + 1, zero_divs);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
